// ===== rtl/p420_pkg.sv =====
// ---------------------------------------------------------------------------
// p420_pkg: shared types and constants of the planar 4:2:0 to RGB24 converter
// Beat payloads, configuration layout, coefficients and derived widths.
// ---------------------------------------------------------------------------
package p420_pkg;

   // Line store depth in pixel pairs.
   localparam int MAX_PAIRS_PER_ROW = 512;
   localparam int MAX_ROWS          = 1024;

   // Configuration register widths and indexes.
   localparam int PPR_W     = 10;
   localparam int RPF_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_PAIRS_PER_ROW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_PER_FRAME = 1'd1;

   localparam logic [PPR_W-1:0] PPR_RESET = 10'd176;
   localparam logic [RPF_W-1:0] RPF_RESET = 11'd288;

   // Counter widths.
   localparam int COL_W  = $clog2(MAX_PAIRS_PER_ROW);
   localparam int WIDE_W = (COL_W + 1 > PPR_W) ? COL_W + 1 : PPR_W;
   localparam int ROW_W  = $clog2(MAX_ROWS);

   // Sample and arithmetic widths.
   localparam int BYTE_W  = 8;
   localparam int COEF_W  = 12;
   localparam int PROD_W  = 20;
   localparam int FRAC_W  = 10;
   localparam int OFF_W   = PROD_W - FRAC_W;
   localparam int SUM_W   = 11;

   localparam logic signed [COEF_W-1:0] COEF_RV = 12'sd1436;
   localparam logic signed [COEF_W-1:0] COEF_GU = 12'sd352;
   localparam logic signed [COEF_W-1:0] COEF_GV = 12'sd731;
   localparam logic signed [COEF_W-1:0] COEF_BU = 12'sd1814;

   typedef struct packed {
      logic [BYTE_W-1:0] luma_left;
      logic [BYTE_W-1:0] luma_right;
      logic [BYTE_W-1:0] chroma_blue;
      logic [BYTE_W-1:0] chroma_red;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red_left;
      logic [BYTE_W-1:0] green_left;
      logic [BYTE_W-1:0] blue_left;
      logic [BYTE_W-1:0] red_right;
      logic [BYTE_W-1:0] green_right;
      logic [BYTE_W-1:0] blue_right;
      logic              row_end;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [PPR_W-1:0] pairs_per_row;
      logic [RPF_W-1:0] rows_per_frame;
   } cfg_type;

   typedef struct packed {
      logic even_row;
      logic row_end;
   } line_status_type;

endpackage

// ===== rtl/p420_line.sv =====
// ---------------------------------------------------------------------------
// p420_line: raster position counters and chroma line store
// Tracks pair column and row, stores chroma on even rows and reads it back
// on odd rows with a registered read port.
// ---------------------------------------------------------------------------
module p420_line (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [2*p420_pkg::BYTE_W-1:0]    chroma_wr,
   input  p420_pkg::cfg_type                cfg,
   output p420_pkg::line_status_type        status,
   output logic [2*p420_pkg::BYTE_W-1:0]    chroma_rd
);
   import p420_pkg::*;

   logic [2*BYTE_W-1:0] line_mem [MAX_PAIRS_PER_ROW];
   logic [2*BYTE_W-1:0] rd_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WIDE_W-1:0] ppr_wide;
   logic [WIDE_W-1:0] width;
   logic [WIDE_W-1:0] col_wide;
   logic [RPF_W-1:0]  height;
   logic [COL_W-1:0]  col;
   logic              last;
   logic              even;

   // Out-of-range settings are pulled back into the legal range.
   always_comb begin
      ppr_wide = WIDE_W'(cfg.pairs_per_row);
      if (ppr_wide == '0) begin
         width = WIDE_W'(1);
      end else if (ppr_wide > WIDE_W'(MAX_PAIRS_PER_ROW)) begin
         width = WIDE_W'(MAX_PAIRS_PER_ROW);
      end else begin
         width = ppr_wide;
      end

      if (cfg.rows_per_frame < RPF_W'(2)) begin
         height = RPF_W'(2);
      end else if (cfg.rows_per_frame > RPF_W'(MAX_ROWS)) begin
         height = RPF_W'(MAX_ROWS);
      end else begin
         height = cfg.rows_per_frame;
      end

      // A column left past a narrowed row ends that row at once.
      if (WIDE_W'(col_ff) >= width) begin
         col_wide = width - WIDE_W'(1);
      end else begin
         col_wide = WIDE_W'(col_ff);
      end
      col  = col_wide[COL_W-1:0];
      last = (col_wide + WIDE_W'(1)) >= width;
      even = ~row_ff[0];
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            if ((RPF_W'(row_ff) + RPF_W'(1)) >= height) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && even) begin
         line_mem[col] <= chroma_wr;
      end
      if (accept) begin
         rd_ff <= line_mem[col];
      end
   end

   assign status.even_row = even;
   assign status.row_end  = last;
   assign chroma_rd       = rd_ff;

endmodule

// ===== rtl/p420_lane.sv =====
// ---------------------------------------------------------------------------
// p420_lane: one pixel conversion lane
// Multiplies chroma by the fixed-point coefficients, registers the offsets,
// then adds luma and clamps each channel to a byte.
// ---------------------------------------------------------------------------
module p420_lane (
   input  logic                        clock,
   input  logic                        load,
   input  logic [p420_pkg::BYTE_W-1:0] luma,
   input  logic [p420_pkg::BYTE_W-1:0] chroma_blue,
   input  logic [p420_pkg::BYTE_W-1:0] chroma_red,
   output p420_pkg::pixel_type         pixel
);
   import p420_pkg::*;

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] x);
      logic [BYTE_W-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > SUM_W'(255)) begin
         r = '1;
      end else begin
         r = x[BYTE_W-1:0];
      end
      return r;
   endfunction

   logic signed [BYTE_W-1:0] u, v;
   logic signed [PROD_W-1:0] prod_r, prod_g, prod_b;

   logic [BYTE_W-1:0]       y_ff;
   logic signed [OFF_W-1:0] off_r_ff, off_g_ff, off_b_ff;

   logic signed [SUM_W-1:0] y_s, sum_r, sum_g, sum_b;

   // Removing the 128 offset is an MSB flip into two's complement.
   assign u = signed'({~chroma_blue[BYTE_W-1], chroma_blue[BYTE_W-2:0]});
   assign v = signed'({~chroma_red[BYTE_W-1], chroma_red[BYTE_W-2:0]});

   assign prod_r = PROD_W'(v) * PROD_W'(COEF_RV);
   assign prod_g = PROD_W'(u) * PROD_W'(COEF_GU) + PROD_W'(v) * PROD_W'(COEF_GV);
   assign prod_b = PROD_W'(u) * PROD_W'(COEF_BU);

   // Dropping the fraction bits of a signed product is a floor shift.
   always_ff @(posedge clock) begin
      if (load) begin
         y_ff     <= luma;
         off_r_ff <= prod_r[PROD_W-1:FRAC_W];
         off_g_ff <= prod_g[PROD_W-1:FRAC_W];
         off_b_ff <= prod_b[PROD_W-1:FRAC_W];
      end
   end

   assign y_s   = signed'({{(SUM_W-BYTE_W){1'b0}}, y_ff});
   assign sum_r = y_s + SUM_W'(off_r_ff);
   assign sum_g = y_s - SUM_W'(off_g_ff);
   assign sum_b = y_s + SUM_W'(off_b_ff);

   assign pixel.red   = clamp_byte(sum_r);
   assign pixel.green = clamp_byte(sum_g);
   assign pixel.blue  = clamp_byte(sum_b);

endmodule

// ===== rtl/planar_yuv420_to_rgb24_unit.sv =====
// ---------------------------------------------------------------------------
// planar_yuv420_to_rgb24_unit: 4:2:0 planar to RGB24 converter
// Converts pairs of luma samples plus shared chroma to two RGB pixels.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Beat contents
//   req_*     in         req_valid/req_ready   two luma bytes, Cb, Cr
//   rsp_*     out        rsp_valid/rsp_ready   two RGB pixels, row_end
//   csr_*     in         csr_we                register index, write data
//
// One pair per clock is sustained while the result side takes beats; each beat
// passes through the line store read stage, the coefficient stage and the
// clamp-and-output register. Reset clears the row and column counters and
// empties the pipeline; the line store needs no clearing. A stall on the
// result side backs up stage by stage, so empty stages keep taking beats.
//
module planar_yuv420_to_rgb24_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  p420_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output p420_pkg::rsp_type               rsp_payload,
   input  logic                            csr_we,
   input  logic [p420_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [p420_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import p420_pkg::*;

   // Configuration registers. They are only to be written while the block is idle; the block does not enforce this.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pairs_per_row  <= PPR_RESET;
         cfg_ff.rows_per_frame <= RPF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PAIRS_PER_ROW:  cfg_ff.pairs_per_row  <= csr_wdata[PPR_W-1:0];
            REG_ROWS_PER_FRAME: cfg_ff.rows_per_frame <= csr_wdata[RPF_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage flow control. A stage may load when it is empty or when its
   // content moves on in the same cycle.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic free1, free2, free3;
   logic accept;

   assign free3  = ~rsp_valid_ff | rsp_ready;
   assign free2  = ~s2_valid_ff | free3;
   assign free1  = ~s1_valid_ff | free2;
   assign accept = req_valid & free1;

   assign s1_valid_in  = free1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = free2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = free3 ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Raster position and chroma line store. On even rows the incoming
   // chroma is written at the pair column; odd rows read it back.
   line_status_type      line_status;
   logic [2*BYTE_W-1:0]  line_rd;

   p420_line u_line (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .chroma_wr ({req_payload.chroma_red, req_payload.chroma_blue}),
      .cfg       (cfg_ff),
      .status    (line_status),
      .chroma_rd (line_rd)
   );

   // Stage one holds the beat while the line store read completes.
   req_type s1_req_ff;
   logic    s1_even_ff;
   logic    s1_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_payload;
         s1_even_ff <= line_status.even_row;
         s1_last_ff <= line_status.row_end;
      end
   end

   // Even rows use their own chroma, odd rows the stored chroma of the row
   // above (Cb in the low byte, Cr in the high byte).
   logic [BYTE_W-1:0] cb_sel, cr_sel;

   assign cb_sel = s1_even_ff ? s1_req_ff.chroma_blue : line_rd[BYTE_W-1:0];
   assign cr_sel = s1_even_ff ? s1_req_ff.chroma_red  : line_rd[2*BYTE_W-1:BYTE_W];

   // Two identical lanes convert the left and right pixel side by side.
   logic      load2;
   pixel_type pix_left, pix_right;

   assign load2 = free2 & s1_valid_ff;

   p420_lane u_lane_left (
      .clock       (clock),
      .load        (load2),
      .luma        (s1_req_ff.luma_left),
      .chroma_blue (cb_sel),
      .chroma_red  (cr_sel),
      .pixel       (pix_left)
   );

   p420_lane u_lane_right (
      .clock       (clock),
      .load        (load2),
      .luma        (s1_req_ff.luma_right),
      .chroma_blue (cb_sel),
      .chroma_red  (cr_sel),
      .pixel       (pix_right)
   );

   logic s2_last_ff;

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // Merge stage: both lanes and the row end flag go into one output beat.
   rsp_type rsp_payload_ff, rsp_payload_in;
   logic    load3;

   assign load3 = free3 & s2_valid_ff;

   always_comb begin
      rsp_payload_in.red_left    = pix_left.red;
      rsp_payload_in.green_left  = pix_left.green;
      rsp_payload_in.blue_left   = pix_left.blue;
      rsp_payload_in.red_right   = pix_right.red;
      rsp_payload_in.green_right = pix_right.green;
      rsp_payload_in.blue_right  = pix_right.blue;
      rsp_payload_in.row_end     = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign req_ready   = free1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/p420_checker.sv =====
// ---------------------------------------------------------------------------
// p420_checker: port-level checks for the 4:2:0 to RGB24 converter
// Tracks beats in flight and checks pipeline occupancy and output stalls.
// ---------------------------------------------------------------------------
module p420_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input p420_pkg::rsp_type rsp_payload
);
   import p420_pkg::*;

   logic [2:0] inflight_ff, inflight_in;

   assign inflight_in = inflight_ff + 3'(req_valid & req_ready) - 3'(rsp_valid & rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // The pipeline holds at most three beats.
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd3)
      else $error("more beats in flight than pipeline stages");

   // A result never appears without an accepted beat behind it.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result beat without an accepted request");

   // An empty block always takes a new beat.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 3'd0 |-> req_ready)
      else $error("empty block refuses a request beat");

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed or dropped");

endmodule

bind planar_yuv420_to_rgb24_unit p420_checker u_p420_checker (.*);
